@@ rtl/core/spd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the signal pending/dispatch controller.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int DEF_NUM_SIGNALS = 64;

    localparam int WORD_W   = 64;
    localparam int MODE_W   = 2;
    localparam int SIGNUM_W = 8;
    localparam int STATUS_W = 3;
    localparam int DSIG_W   = 7;

    // event modes
    localparam logic [MODE_W-1:0] MODE_SEND     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACTION   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd2;

    // send status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IS_KILL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRONG_TYPE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DENIED     = 3'd4;

    // special signal numbers
    localparam logic [SIGNUM_W-1:0] SIG_KILL_NUM = 8'd9;
    localparam logic [SIGNUM_W-1:0] SIG_INT_NUM  = 8'd2;

    // handler values that mean default action and ignore
    localparam logic [WORD_W-1:0] HANDLER_DFL = 64'd0;
    localparam logic [WORD_W-1:0] HANDLER_IGN = 64'd1;

    // register frame (88) + 8, plus the 8 taken off before alignment
    localparam logic [WORD_W-1:0] STACK_DROP = 64'd104;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   old_handler;
        logic [WORD_W-1:0]   old_restorer;
        logic [DSIG_W-1:0]   delivered_signal;
        logic [WORD_W-1:0]   handler_address;
        logic [WORD_W-1:0]   new_stack;
        logic [WORD_W-1:0]   frame_address;
        logic [WORD_W-1:0]   return_address;
        logic                kill_request;
    } t_result;

    // handshake between the sequencer and the output stage
    typedef struct packed {
        logic    push;
        t_result res;
    } t_push;

endpackage
`default_nettype wire

@@ rtl/core/spd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spd_in_if / spd_out_if
// Valid/ready channels for event words in and result words out.
// ----------------------------------------------------------------------------
interface spd_in_if import spd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SIGNUM_W-1:0] sig_num;
    logic                handle_valid;
    logic                handle_is_thread;
    logic                handle_can_signal;
    logic                query_old;
    logic                set_new;
    logic [WORD_W-1:0]   install_handler;
    logic [WORD_W-1:0]   install_restorer;
    logic [WORD_W-1:0]   user_stack_pointer;

    modport source (
        output valid, mode, sig_num, handle_valid, handle_is_thread,
               handle_can_signal, query_old, set_new, install_handler,
               install_restorer, user_stack_pointer,
        input  ready
    );
    modport sink (
        input  valid, mode, sig_num, handle_valid, handle_is_thread,
               handle_can_signal, query_old, set_new, install_handler,
               install_restorer, user_stack_pointer,
        output ready
    );
endinterface

interface spd_out_if import spd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   old_handler;
    logic [WORD_W-1:0]   old_restorer;
    logic [DSIG_W-1:0]   delivered_signal;
    logic [WORD_W-1:0]   handler_address;
    logic [WORD_W-1:0]   new_stack;
    logic [WORD_W-1:0]   frame_address;
    logic [WORD_W-1:0]   return_address;
    logic                kill_request;

    modport source (
        output valid, status, old_handler, old_restorer, delivered_signal,
               handler_address, new_stack, frame_address, return_address,
               kill_request,
        input  ready
    );
    modport sink (
        input  valid, status, old_handler, old_restorer, delivered_signal,
               handler_address, new_stack, frame_address, return_address,
               kill_request,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/spd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/spd_out_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spd_out_reg
// Output register stage: holds one finished result word until taken.
// ----------------------------------------------------------------------------
module spd_out_reg import spd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_free,
    spd_out_if.source  o_res
);

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.push && o_free) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push && o_free) begin
            r_data <= i_push.res;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.status           = r_data.status;
    assign o_res.old_handler      = r_data.old_handler;
    assign o_res.old_restorer     = r_data.old_restorer;
    assign o_res.delivered_signal = r_data.delivered_signal;
    assign o_res.handler_address  = r_data.handler_address;
    assign o_res.new_stack        = r_data.new_stack;
    assign o_res.frame_address    = r_data.frame_address;
    assign o_res.return_address   = r_data.return_address;
    assign o_res.kill_request     = r_data.kill_request;

endmodule
`default_nettype wire

@@ rtl/core/signal_pending_dispatch_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signal_pending_dispatch_core
// Per-thread signal controller: pending mask, handler/restorer table, dispatch.
// ----------------------------------------------------------------------------
//   i_evt carries one event word (send, action or dispatch); o_res returns
//   exactly one result word per event, in order. i_cfg_we/i_cfg_wdata write
//   the blocked mask; write it only while no event is in flight.
//   Handler and restorer share one RAM row per signal (registered
//   read); a valid flop per row makes unwritten rows read as zero.
//   States per event, accept to next accept with o_res free (the result word
//   is valid on o_res from the cycle in which i_evt.ready rises again):
//     send / bad action / undefined mode : S_IDLE, S_PUSH
//     action   : S_IDLE (RAM read), S_ACT (write back), S_PUSH
//     dispatch : S_IDLE, S_SCAN (RAM read) + S_EVAL per signal, S_PUSH
//   When nothing is delivered, the walk ends with an S_SCAN on an empty walk.
//   i_evt.ready is high only while the sequencer idles; a stalled receiver
//   holds the output register and one finished word waiting behind it.
//   Reset clears pending bits, table valid bits and the blocked mask at once,
//   so events are accepted right after reset.
// ----------------------------------------------------------------------------
module signal_pending_dispatch_core import spd_pkg::*; #(
    parameter int NUM_SIGNALS = DEF_NUM_SIGNALS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [WORD_W-1:0]  i_cfg_wdata,
    spd_in_if.sink                  i_evt,
    spd_out_if.source               o_res
);

    localparam int IDX_W = $clog2(NUM_SIGNALS);
    localparam int PW    = NUM_SIGNALS - 1;   // bit s-1 tracks signal s

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACT  = 5'b00010,
        S_SCAN = 5'b00100,
        S_EVAL = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    // control state
    t_state            r_state,   n_state;
    logic [PW-1:0]     r_pending, n_pending;
    logic [PW-1:0]     r_blocked;
    logic [NUM_SIGNALS-1:0] r_tvalid, n_tvalid;

    // per-event working registers
    logic [PW-1:0]     r_walk,     n_walk;
    logic [IDX_W-1:0]  r_sig,      n_sig;
    logic              r_want_old, n_want_old;
    logic              r_set_new,  n_set_new;
    logic [WORD_W-1:0] r_new_h,    n_new_h;
    logic [WORD_W-1:0] r_new_r,    n_new_r;
    logic [WORD_W-5:0] r_base,     n_base;
    t_result           r_res,      n_res;

    // table RAM
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [2*WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0]   rd_handler;
    logic [WORD_W-1:0]   rd_restorer;

    // scan helpers
    logic [PW-1:0]     walk_low;
    logic [IDX_W-1:0]  scan_sig;

    logic [WORD_W-1:0]   usp_adj;
    logic [SIGNUM_W-1:0] sig_in;
    logic                sig_ok;
    logic                accept;
    logic                out_free;
    t_push               push;

    assign accept = i_evt.valid && i_evt.ready;
    assign i_evt.ready = (r_state == S_IDLE);

    assign sig_in  = i_evt.sig_num;
    assign sig_ok  = (sig_in != '0) && (sig_in < SIGNUM_W'(NUM_SIGNALS));
    assign usp_adj = i_evt.user_stack_pointer - STACK_DROP;

    // unwritten rows read as zero
    assign rd_handler  = r_tvalid[r_sig] ? ram_rdata[WORD_W-1:0] : '0;
    assign rd_restorer = r_tvalid[r_sig] ? ram_rdata[2*WORD_W-1:WORD_W] : '0;

    // lowest remaining signal of the walk
    assign walk_low = r_walk & (~r_walk + PW'(1));

    always_comb begin
        scan_sig = '0;
        for (int i = 0; i < PW; i++) begin
            if (walk_low[i]) begin
                scan_sig = scan_sig | IDX_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_tvalid   = r_tvalid;
        n_walk     = r_walk;
        n_sig      = r_sig;
        n_want_old = r_want_old;
        n_set_new  = r_set_new;
        n_new_h    = r_new_h;
        n_new_r    = r_new_r;
        n_base     = r_base;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_raddr  = r_sig;
        push.push  = 1'b0;
        push.res   = r_res;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // latch the event and clear the result
                    n_res      = '0;
                    n_sig      = sig_in[IDX_W-1:0];
                    n_want_old = i_evt.query_old;
                    n_set_new  = i_evt.set_new;
                    n_new_h    = i_evt.install_handler;
                    n_new_r    = i_evt.install_restorer;
                    n_base     = usp_adj[WORD_W-1:4];
                    n_state    = S_PUSH;
                    case (i_evt.mode)
                        MODE_SEND: begin
                            if (!sig_ok) begin
                                n_res.status = ST_INVALID;
                            end else if (sig_in == SIG_KILL_NUM) begin
                                n_res.status = ST_IS_KILL;
                            end else if (!i_evt.handle_valid) begin
                                n_res.status = ST_INVALID;
                            end else if (!i_evt.handle_is_thread) begin
                                n_res.status = ST_WRONG_TYPE;
                            end else if (!i_evt.handle_can_signal) begin
                                n_res.status = ST_DENIED;
                            end else begin
                                n_res.status = ST_OK;
                                n_pending = r_pending
                                    | (PW'(1) << (sig_in[IDX_W-1:0] - IDX_W'(1)));
                            end
                        end
                        MODE_ACTION: begin
                            if (sig_ok && sig_in != SIG_KILL_NUM) begin
                                ram_raddr = sig_in[IDX_W-1:0];
                                n_state   = S_ACT;
                            end
                        end
                        MODE_DISPATCH: begin
                            n_walk  = r_pending & ~r_blocked;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end

            S_ACT: begin
                // old contents arrive now; write back the new row if asked
                if (r_want_old) begin
                    n_res.old_handler  = rd_handler;
                    n_res.old_restorer = rd_restorer;
                end
                if (r_set_new) begin
                    ram_we          = 1'b1;
                    n_tvalid[r_sig] = 1'b1;
                end
                n_state = S_PUSH;
            end

            S_SCAN: begin
                if (r_walk == '0) begin
                    n_state = S_PUSH;
                end else begin
                    // visit: read the row and drop the pending bit
                    ram_raddr = scan_sig;
                    n_sig     = scan_sig;
                    n_walk    = r_walk & ~walk_low;
                    n_pending = r_pending & ~walk_low;
                    n_state   = S_EVAL;
                end
            end

            S_EVAL: begin
                if (rd_handler == HANDLER_DFL && SIGNUM_W'(r_sig) == SIG_INT_NUM) begin
                    n_res.kill_request = 1'b1;
                    n_state = S_SCAN;
                end else if (rd_handler == HANDLER_DFL || rd_handler == HANDLER_IGN) begin
                    n_state = S_SCAN;
                end else begin
                    n_res.delivered_signal = DSIG_W'(r_sig);
                    n_res.handler_address  = rd_handler;
                    n_res.return_address   = rd_restorer;
                    n_res.new_stack        = {r_base, 4'h8};
                    n_res.frame_address    = {r_base + (WORD_W-4)'(1), 4'h0};
                    n_state = S_PUSH;
                end
            end

            S_PUSH: begin
                push.push = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= '0;
            r_tvalid  <= '0;
            r_blocked <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_tvalid  <= n_tvalid;
            if (i_cfg_we) begin
                r_blocked <= i_cfg_wdata[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk     <= n_walk;
        r_sig      <= n_sig;
        r_want_old <= n_want_old;
        r_set_new  <= n_set_new;
        r_new_h    <= n_new_h;
        r_new_r    <= n_new_r;
        r_base     <= n_base;
        r_res      <= n_res;
    end

    spd_ram #(
        .WIDTH (2*WORD_W),
        .DEPTH (NUM_SIGNALS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sig),
        .i_wdata ({r_new_r, r_new_h}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
